[design/acab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_pkg
// Shared types and constants for the automaton builder.
// ----------------------------------------------------------------------------
package acab_pkg;
    localparam int MAX_NODES   = 256;
    localparam int MAX_SYMBOLS = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int SYM_W       = $clog2(MAX_SYMBOLS);
    localparam int TT_DEPTH    = MAX_NODES * MAX_SYMBOLS;
    localparam int TT_AW       = NODE_W + SYM_W;
    localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SYM  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BUILT    = 2'd3;

    typedef enum logic [3:0] {
        S_WIPE, S_CLR, S_IDLE, S_INS_RD, S_INS_WR, S_INS_TRM, S_QRY_RD, S_QRY_OUT,
        S_B_POP, S_B_PRD, S_B_FP, S_B_SYM, S_B_RD, S_B_WR, S_B_TRM, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic wipe_step;
        logic wipe_start;
        logic take_req;
        logic ins_rd;
        logic ins_wr;
        logic ins_trm;
        logic qry_rd;
        logic qry_cap;
        logic b_init;
        logic b_pop;
        logic b_prd;
        logic b_fp;
        logic b_sym;
        logic b_rd;
        logic b_wr;
        logic b_trm;
        logic b_done;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic wipe_last;
        logic queue_more;
        logic sym_more;
        logic built;
    } sts_t;
endpackage

[design/acab_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_req_if / acab_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface acab_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] symbol;
    logic       pattern_end;
    logic [7:0] query_node;
    modport source (output valid, req_type, symbol, pattern_end, query_node, input ready);
    modport sink (input valid, req_type, symbol, pattern_end, query_node, output ready);
endinterface

interface acab_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] next_node;
    logic [7:0] fail_node;
    logic       terminal;
    logic [7:0] node_count;
    modport source (output valid, status, next_node, fail_node, terminal, node_count,
                    input ready);
    modport sink (input valid, status, next_node, fail_node, terminal, node_count,
                  output ready);
endinterface

[design/acab_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module acab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[design/acab_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_ctrl
// Sequencer for wipe, insert, query and breadth-first build.
// ----------------------------------------------------------------------------
module acab_ctrl import acab_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_type,
    input  logic       out_busy,
    input  sts_t       sts,
    output logic       in_ready,
    output cmd_t       cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_WIPE:    if (sts.wipe_last) state_next = S_IDLE;
            S_CLR:     if (sts.wipe_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid && !out_busy)
                begin
                    case (in_type)
                        REQ_INSERT: state_next = S_INS_RD;
                        REQ_BUILD:  state_next = sts.built ? S_OUT : S_B_POP;
                        REQ_QUERY:  state_next = S_QRY_RD;
                        default:    state_next = S_CLR;
                    endcase
                end
            end
            S_INS_RD:  state_next = S_INS_WR;
            S_INS_WR:  state_next = S_INS_TRM;
            S_INS_TRM: state_next = S_IDLE;
            S_QRY_RD:  state_next = S_QRY_OUT;
            S_QRY_OUT: state_next = S_IDLE;
            S_B_POP:   state_next = sts.queue_more ? S_B_PRD : S_OUT;
            S_B_PRD:   state_next = S_B_FP;
            S_B_FP:    state_next = S_B_SYM;
            S_B_SYM:   state_next = sts.sym_more ? S_B_RD : S_B_POP;
            S_B_RD:    state_next = S_B_WR;
            S_B_WR:    state_next = S_B_TRM;
            S_B_TRM:   state_next = S_B_SYM;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = (state_reg == S_IDLE) && !out_busy;
        cmd.take_req = in_ready && in_valid;
        cmd.wipe_start = cmd.take_req && (in_type == REQ_CLEAR);
        cmd.b_init = cmd.take_req && (in_type == REQ_BUILD) && !sts.built;
        case (state_reg)
            S_WIPE:    cmd.wipe_step = 1'b1;
            S_CLR:     cmd.wipe_step = 1'b1;
            S_INS_RD:  cmd.ins_rd = 1'b1;
            S_INS_WR:  cmd.ins_wr = 1'b1;
            S_INS_TRM: cmd.ins_trm = 1'b1;
            S_QRY_RD:  cmd.qry_rd = 1'b1;
            S_QRY_OUT: cmd.qry_cap = 1'b1;
            S_B_POP:   cmd.b_pop = 1'b1;
            S_B_PRD:   cmd.b_prd = 1'b1;
            S_B_FP:    cmd.b_fp = 1'b1;
            S_B_SYM:   cmd.b_sym = 1'b1;
            S_B_RD:    cmd.b_rd = 1'b1;
            S_B_WR:    cmd.b_wr = 1'b1;
            S_B_TRM:   cmd.b_trm = 1'b1;
            S_OUT:     cmd.b_done = 1'b1;
            default:   ;
        endcase
        // clear result goes out when the sweep finishes; the reset sweep has none
        cmd.out_load = cmd.ins_trm || cmd.qry_cap || cmd.b_done
                       || ((state_reg == S_CLR) && sts.wipe_last);
    end
endmodule

[design/acab_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_dp
// Tables, BFS queue, insert cursor and result register.
// ----------------------------------------------------------------------------
module acab_dp import acab_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [6:0]        alpha_cfg,
    input  logic [1:0]        in_type,
    input  logic [5:0]        in_symbol,
    input  logic              in_pend,
    input  logic [7:0]        in_node,
    input  logic              out_ready,
    output sts_t              sts,
    output logic              out_valid,
    output logic [1:0]        out_status,
    output logic [7:0]        out_next,
    output logic [7:0]        out_fail,
    output logic              out_term,
    output logic [7:0]        out_count
);
    // transition, fail-link, terminal and queue memories, all registered read
    logic              tt_we;
    logic [TT_AW-1:0]  tt_addr;
    logic [NODE_W-1:0] tt_wdata, tt_rdata;
    logic              q_we;
    logic [NODE_W-1:0] q_addr, q_wdata, q_rdata;
    logic              fail_we;
    logic [NODE_W-1:0] fail_addr, fail_wdata, fail_rdata;
    logic              term_we;
    logic [NODE_W-1:0] term_addr;
    logic              term_wdata, term_rdata;

    acab_ram #(.WIDTH(NODE_W), .DEPTH(TT_DEPTH)) u_tt (
        .clk(clk), .we(tt_we), .addr(tt_addr), .wdata(tt_wdata), .rdata(tt_rdata)
    );
    acab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_q (
        .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
    );
    acab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(fail_we), .addr(fail_addr), .wdata(fail_wdata), .rdata(fail_rdata)
    );
    acab_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
        .clk(clk), .we(term_we), .addr(term_addr), .wdata(term_wdata), .rdata(term_rdata)
    );

    logic [TT_AW-1:0]  wipe_reg;
    logic [NODE_W:0]   used_reg;
    logic [NODE_W-1:0] cur_reg;
    logic              built_reg;
    logic [NODE_W:0]   head_reg, tail_reg;
    logic [NODE_W-1:0] p_reg, fp_reg, child_reg;
    logic [NODE_W-1:0] ins_node_reg;
    logic              ins_ok_reg;
    logic [SYM_W:0]    c_reg;
    logic [1:0]        rtype_reg;
    logic [5:0]        rsym_reg;
    logic              rpend_reg;
    logic [7:0]        rnode_reg;
    logic              vld_reg;
    logic [1:0]        st_reg;
    logic [7:0]        nx_reg, fl_reg, cnt_reg;
    logic              tm_reg;

    logic [7:0] eff;
    logic       sym_ok, node_ok;
    assign eff     = (alpha_cfg > 7'(MAX_SYMBOLS)) ? 8'(MAX_SYMBOLS) : 8'(alpha_cfg);
    assign sym_ok  = 8'(rsym_reg) < eff;
    assign node_ok = 9'(rnode_reg) < 9'(MAX_NODES);

    logic [SYM_W-1:0]  sidx;
    logic [NODE_W-1:0] nidx, via;
    logic              full, ins_ok;
    assign sidx   = rsym_reg[SYM_W-1:0];
    assign nidx   = rnode_reg[NODE_W-1:0];
    assign full   = (used_reg + 1'b1) > (NODE_W+1)'(MAX_NODES - 1);
    assign ins_ok = !built_reg && sym_ok && !((tt_rdata == '0) && full);

    // build step: child read in B_RD, via read in B_WR comes from fp row
    logic [NODE_W-1:0] ins_node;
    assign ins_node = (tt_rdata == '0) ? used_reg[NODE_W-1:0] + 1'b1 : tt_rdata;
    assign via = (p_reg == ROOT) ? ROOT : tt_rdata;

    always_comb
    begin
        tt_we      = 1'b0;
        tt_addr    = {cur_reg, sidx};
        tt_wdata   = ins_node;
        q_we       = 1'b0;
        q_addr     = head_reg[NODE_W-1:0];
        q_wdata    = ROOT;
        fail_we    = 1'b0;
        fail_addr  = nidx;
        fail_wdata = via;
        term_we    = 1'b0;
        term_addr  = nidx;
        term_wdata = 1'b1;
        if (cmd.wipe_step)
        begin
            tt_we = 1'b1; tt_addr = wipe_reg; tt_wdata = '0;
            fail_we = 1'b1; fail_addr = wipe_reg[NODE_W-1:0]; fail_wdata = '0;
            term_we = 1'b1; term_addr = wipe_reg[NODE_W-1:0]; term_wdata = 1'b0;
        end
        else if (cmd.qry_rd)
        begin
            tt_addr = {nidx, sidx};
        end
        else if (cmd.ins_wr)
        begin
            tt_we = ins_ok && (tt_rdata == '0);
            term_addr = ins_node;
        end
        else if (cmd.ins_trm)
        begin
            term_addr = ins_node_reg;
            term_we = ins_ok_reg && rpend_reg;
        end
        else if (cmd.b_init)
        begin
            q_we = 1'b1; q_addr = '0;
            fail_we = 1'b1; fail_addr = ROOT; fail_wdata = ROOT;
        end
        else if (cmd.b_prd)
        begin
            fail_addr = q_rdata;
        end
        else if (cmd.b_sym)
        begin
            tt_addr = {p_reg, c_reg[SYM_W-1:0]};
        end
        else if (cmd.b_rd)
        begin
            tt_addr = {fp_reg, c_reg[SYM_W-1:0]};
        end
        else if (cmd.b_wr)
        begin
            tt_addr = {p_reg, c_reg[SYM_W-1:0]};
            tt_wdata = via;
            tt_we = (child_reg == '0);
            q_we = (child_reg != '0) && !tail_reg[NODE_W];
            q_addr = tail_reg[NODE_W-1:0];
            q_wdata = child_reg;
            fail_addr = child_reg;
            fail_we = (child_reg != '0);
            term_addr = via;
        end
        else if (cmd.b_trm)
        begin
            // child inherits the terminal flag of its fail target
            term_addr = child_reg;
            term_we = (child_reg != '0) && term_rdata;
        end
    end

    assign sts.wipe_last  = (wipe_reg == TT_AW'(TT_DEPTH - 1));
    assign sts.queue_more = (head_reg < tail_reg) && !head_reg[NODE_W];
    assign sts.sym_more   = 8'(c_reg) < eff;
    assign sts.built      = built_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_reg  <= '0;
            used_reg  <= (NODE_W+1)'(1);
            cur_reg   <= ROOT;
            built_reg <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (vld_reg && out_ready) vld_reg <= 1'b0;
            if (cmd.out_load) vld_reg <= 1'b1;
            if (cmd.wipe_start)
            begin
                wipe_reg  <= '0;
                used_reg  <= (NODE_W+1)'(1);
                cur_reg   <= ROOT;
                built_reg <= 1'b0;
                head_reg  <= '0;
                tail_reg  <= '0;
            end
            if (cmd.wipe_step) wipe_reg <= wipe_reg + 1'b1;
            if (cmd.ins_wr)
            begin
                ins_node_reg <= ins_node;
                ins_ok_reg   <= ins_ok;
            end
            if (cmd.ins_wr && ins_ok)
            begin
                if (tt_rdata == '0) used_reg <= used_reg + 1'b1;
                if (rpend_reg)
                begin
                    cur_reg <= ROOT;
                end
                else
                begin
                    cur_reg <= ins_node;
                end
            end
            if (cmd.b_init)
            begin
                head_reg <= '0;
                tail_reg <= (NODE_W+1)'(1);
            end
            if (cmd.b_pop && sts.queue_more) head_reg <= head_reg + 1'b1;
            if (cmd.b_prd) p_reg <= q_rdata;
            if (cmd.b_fp)
            begin
                fp_reg <= fail_rdata;
                c_reg  <= '0;
            end
            if (cmd.b_rd) child_reg <= tt_rdata;
            if (cmd.b_wr)
            begin
                c_reg <= c_reg + 1'b1;
                if ((child_reg != '0) && !tail_reg[NODE_W]) tail_reg <= tail_reg + 1'b1;
            end
            if (cmd.b_done && rtype_reg == REQ_BUILD && !built_reg)
            begin
                built_reg <= 1'b1;
                cur_reg <= ROOT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            rtype_reg <= in_type;
            rsym_reg  <= in_symbol;
            rpend_reg <= in_pend;
            rnode_reg <= in_node;
        end
        // insert fields settle in the cycle before the terminal flag arrives
        if (cmd.ins_wr || (cmd.out_load && !cmd.ins_trm))
        begin
            st_reg <= ST_OK;
            nx_reg <= '0;
            fl_reg <= '0;
            tm_reg <= 1'b0;
            cnt_reg <= cmd.wipe_step ? 8'd1 : 8'(used_reg);
            if (cmd.ins_wr)
            begin
                if (built_reg) st_reg <= ST_BUILT;
                else if (!sym_ok) st_reg <= ST_BAD_SYM;
                else if (!ins_ok) st_reg <= ST_FULL;
                else
                begin
                    nx_reg <= 8'(ins_node);
                    cnt_reg <= 8'(used_reg + ((tt_rdata == '0) ? 1'b1 : 1'b0));
                end
            end
            if (cmd.qry_cap)
            begin
                if (!sym_ok) st_reg <= ST_BAD_SYM;
                if (node_ok)
                begin
                    if (sym_ok) nx_reg <= 8'(tt_rdata);
                    fl_reg <= 8'(fail_rdata);
                    tm_reg <= term_rdata;
                end
            end
        end
        if (cmd.ins_trm && ins_ok_reg)
        begin
            tm_reg <= rpend_reg | term_rdata;
        end
    end

    assign out_valid  = vld_reg;
    assign out_status = st_reg;
    assign out_next   = nx_reg;
    assign out_fail   = fl_reg;
    assign out_term   = tm_reg;
    assign out_count  = cnt_reg;
endmodule

[design/aho_corasick_automaton_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_automaton_builder
// Builds and serves an Aho-Corasick transition table over mapped symbols.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   req_type, symbol, pattern_end, query_node
//  rsp      out  status, next_node, fail_node, terminal, node_count
//  cfg      in   cfg_we / cfg_data: alphabet_size
//
// Insert steps through INS_RD, INS_WR and INS_TRM, query through QRY_RD and QRY_OUT,
// one pass through the registered-read transition and flag RAMs.
// Build pops each node reached from the queue, then walks every symbol in use.
// Reset and clear sweep the 16384-entry transition RAM, one entry a cycle,
// with no request taken meanwhile; the clear result follows the sweep.
// A new request is taken only while no result waits on rsp.
module aho_corasick_automaton_builder import acab_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data,
    acab_req_if.sink   req,
    acab_rsp_if.source rsp
);
    logic [6:0] alpha_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            alpha_reg <= cfg_data;
        end
    end

    acab_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_type(req.req_type),
        .out_busy(rsp.valid), .sts(sts), .in_ready(req.ready), .cmd(cmd)
    );

    acab_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .alpha_cfg(alpha_reg),
        .in_type(req.req_type), .in_symbol(req.symbol), .in_pend(req.pattern_end),
        .in_node(req.query_node), .out_ready(rsp.ready), .sts(sts),
        .out_valid(rsp.valid), .out_status(rsp.status), .out_next(rsp.next_node),
        .out_fail(rsp.fail_node), .out_term(rsp.terminal), .out_count(rsp.node_count)
    );
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the automaton builder against a behavioral trie/automaton model:
// directed cases, a full-table fill, then random patterns, builds and
// queries under several sender/receiver idle mixes and one long stall.
// ----------------------------------------------------------------------------
module testbench;
    import acab_pkg::*;

    typedef struct {
        logic [1:0] status;
        logic [7:0] next_node;
        logic [7:0] fail_node;
        logic       terminal;
        logic [7:0] node_count;
    } answer_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_data;

    acab_req_if req_if ();
    acab_rsp_if rsp_if ();

    aho_corasick_automaton_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_if),
        .rsp      (rsp_if)
    );

    // model of the automaton store
    logic [7:0] trie_next [0:TT_DEPTH-1];
    logic [7:0] fail_link [0:MAX_NODES-1];
    logic       is_term   [0:MAX_NODES-1];
    int         node_total;
    int         walk_node;
    bit         automaton_done;
    int         alpha_reg;

    answer_t    pending_answers[$];
    int         src_idle_pct;
    int         snk_idle_pct;
    int         stall_left;
    int         error_count;
    bit         last_was_clear;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int usable_symbols();
        return (alpha_reg < MAX_SYMBOLS) ? alpha_reg : MAX_SYMBOLS;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < TT_DEPTH; i++)
            trie_next[i] = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            fail_link[i] = '0;
            is_term[i]   = 1'b0;
        end
        node_total     = 1;
        walk_node      = ROOT;
        automaton_done = 1'b0;
    endfunction

    // breadth-first pass: fail links, terminal propagation, fill gaps
    function automatic void link_automaton();
        int order [0:MAX_NODES-1];
        int head;
        int tail;
        int na;
        int p;
        int fp;
        int child;
        int via;
        na = usable_symbols();
        head = 0;
        tail = 1;
        order[0] = ROOT;
        fail_link[ROOT] = ROOT;
        while (head < tail && head < MAX_NODES)
        begin
            p = order[head];
            head++;
            fp = fail_link[p];
            for (int c = 0; c < na; c++)
            begin
                child = trie_next[p * MAX_SYMBOLS + c];
                via = (p == ROOT) ? ROOT : trie_next[fp * MAX_SYMBOLS + c];
                if (child != 0)
                begin
                    fail_link[child] = 8'(via);
                    is_term[child] = is_term[child] | is_term[via];
                    if (tail < MAX_NODES)
                    begin
                        order[tail] = child;
                        tail++;
                    end
                end
                else
                    trie_next[p * MAX_SYMBOLS + c] = 8'(via);
            end
        end
        walk_node = ROOT;
        automaton_done = 1'b1;
    endfunction

    function automatic answer_t apply_request(logic [1:0] kind, logic [5:0] sym,
                                              logic pend, logic [7:0] qn);
        answer_t a;
        bit sym_ok;
        int idx;
        int node;
        a = '{ST_OK, 8'd0, 8'd0, 1'b0, 8'd0};
        sym_ok = sym < usable_symbols();
        case (kind)
            REQ_INSERT:
            begin
                if (automaton_done)
                    a.status = ST_BUILT;
                else if (!sym_ok)
                    a.status = ST_BAD_SYM;
                else
                begin
                    idx = walk_node * MAX_SYMBOLS + sym;
                    node = trie_next[idx];
                    if (node == 0)
                    begin
                        if (node_total + 1 > MAX_NODES - 1)
                            a.status = ST_FULL;
                        else
                        begin
                            node_total++;
                            node = node_total;
                            trie_next[idx] = 8'(node);
                        end
                    end
                    if (a.status == ST_OK)
                    begin
                        if (pend)
                        begin
                            is_term[node] = 1'b1;
                            walk_node = ROOT;
                        end
                        else
                            walk_node = node;
                        a.next_node = 8'(node);
                        a.terminal  = is_term[node];
                    end
                end
            end
            REQ_BUILD:
            begin
                if (!automaton_done)
                    link_automaton();
            end
            REQ_QUERY:
            begin
                if (sym_ok)
                    a.next_node = trie_next[qn * MAX_SYMBOLS + sym];
                else
                    a.status = ST_BAD_SYM;
                a.fail_node = fail_link[qn];
                a.terminal  = is_term[qn];
            end
            default:
                wipe_store();
        endcase
        a.node_count = 8'(node_total);
        return a;
    endfunction

    // receiver: random stalls, or a long hold-off when stall_left is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result beat status=%0d", $time, rsp_if.status);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             rsp_if.status);
                    error_count++;
                end
                if (rsp_if.next_node !== want.next_node)
                begin
                    $display("%0t: next_node exp %0d got %0d", $time, want.next_node,
                             rsp_if.next_node);
                    error_count++;
                end
                if (rsp_if.fail_node !== want.fail_node)
                begin
                    $display("%0t: fail_node exp %0d got %0d", $time, want.fail_node,
                             rsp_if.fail_node);
                    error_count++;
                end
                if (rsp_if.terminal !== want.terminal)
                begin
                    $display("%0t: terminal exp %0d got %0d", $time, want.terminal,
                             rsp_if.terminal);
                    error_count++;
                end
                if (rsp_if.node_count !== want.node_count)
                begin
                    $display("%0t: node_count exp %0d got %0d", $time, want.node_count,
                             rsp_if.node_count);
                    error_count++;
                end
            end
        end
    end

    // offer one beat and hold it until taken; valid stays up for the next one
    task automatic send_req(logic [1:0] kind, logic [5:0] sym, logic pend, logic [7:0] qn);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid       <= 1'b0;
            req_if.req_type    <= 2'($urandom);
            req_if.symbol      <= 6'($urandom);
            req_if.pattern_end <= 1'($urandom);
            req_if.query_node  <= 8'($urandom);
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.symbol      <= sym;
        req_if.pattern_end <= pend;
        req_if.query_node  <= qn;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_answers.push_back(apply_request(kind, sym, pend, qn));
        last_was_clear = (kind == REQ_CLEAR);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        // after a clear, wait longer than a full table sweep before going on
        if (last_was_clear)
            repeat (TT_DEPTH + 100) @(posedge clk);
        else
            repeat (20) @(posedge clk);
    endtask

    task automatic set_alphabet(int value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= 7'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
        alpha_reg = value;
    endtask

    task automatic insert_pattern(int len, bit finish);
        int hi;
        hi = (usable_symbols() > 0) ? usable_symbols() - 1 : 0;
        for (int i = 0; i < len; i++)
            send_req(REQ_INSERT, 6'($urandom_range(hi)), finish && (i == len - 1),
                     8'($urandom));
    endtask

    task automatic test_directed();
        send_req(REQ_QUERY, 6'd0, 1'b0, 8'd1);
        send_req(REQ_QUERY, 6'd63, 1'b1, 8'd255);
        send_req(REQ_INSERT, 6'd0, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd1, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd2, 1'b1, 8'd0);
        send_req(REQ_INSERT, 6'd1, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd2, 1'b1, 8'd0);
        send_req(REQ_INSERT, 6'd63, 1'b1, 8'd0);
        send_req(REQ_INSERT, 6'd5, 1'b0, 8'd0);      // left unfinished
        send_req(REQ_BUILD, 6'd0, 1'b0, 8'd0);
        send_req(REQ_BUILD, 6'd0, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd3, 1'b1, 8'd0);
        send_req(REQ_QUERY, 6'd2, 1'b0, 8'd3);
        send_req(REQ_QUERY, 6'd2, 1'b0, 8'd5);
        send_req(REQ_QUERY, 6'd7, 1'b0, 8'd0);
        set_alphabet(4);
        send_req(REQ_CLEAR, 6'd0, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd5, 1'b1, 8'd0);
        send_req(REQ_QUERY, 6'd4, 1'b0, 8'd1);
        send_req(REQ_QUERY, 6'd3, 1'b0, 8'd1);
        set_alphabet(0);
        send_req(REQ_CLEAR, 6'd0, 1'b0, 8'd0);
        send_req(REQ_INSERT, 6'd0, 1'b1, 8'd0);
        send_req(REQ_BUILD, 6'd0, 1'b0, 8'd0);
        send_req(REQ_QUERY, 6'd0, 1'b0, 8'd1);
        set_alphabet(127);
        send_req(REQ_QUERY, 6'd63, 1'b0, 8'd1);
    endtask

    task automatic test_table_full();
        set_alphabet(2);
        send_req(REQ_CLEAR, 6'd0, 1'b0, 8'd0);
        for (int i = 0; i < MAX_NODES - 1; i++)
            send_req(REQ_INSERT, 6'($urandom_range(1)), 1'b0, 8'($urandom));
        send_req(REQ_BUILD, 6'd0, 1'b0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_req(REQ_QUERY, 6'($urandom_range(2)), 1'b0, 8'($urandom_range(250, 255)));
    endtask

    task automatic test_random_round();
        int pick;
        pick = $urandom_range(5);
        set_alphabet(pick == 0 ? 1 : pick == 1 ? 64 : pick == 2 ? 127 :
                     $urandom_range(2, 70));
        send_req(REQ_CLEAR, 6'd0, 1'b0, 8'd0);
        repeat ($urandom_range(3, 6))
            insert_pattern($urandom_range(1, 5), $urandom_range(9) != 0);
        repeat (3)
            send_req(2'($urandom), 6'($urandom), 1'($urandom), 8'($urandom));
        send_req(REQ_BUILD, 6'd0, 1'b0, 8'd0);
        repeat (12)
            send_req(REQ_QUERY, 6'($urandom_range(usable_symbols())),
                     1'($urandom),
                     8'($urandom_range(3) == 0 ? $urandom : $urandom_range(node_total)));
        send_req(REQ_INSERT, 6'($urandom), 1'($urandom), 8'($urandom));
        send_req(REQ_QUERY, 6'($urandom), 1'b0, 8'($urandom_range(node_total)));
    endtask

    task automatic test_long_stall();
        stall_left = 300;
        repeat (12)
            send_req(REQ_QUERY, 6'($urandom), 1'($urandom), 8'($urandom));
    endtask

    initial
    begin
        error_count  = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_left   = 0;
        alpha_reg    = 64;
        wipe_store();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= 7'd64;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_QUERY;
        req_if.symbol      <= '0;
        req_if.pattern_end <= 1'b0;
        req_if.query_node  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 32;
        snk_idle_pct = 84;
        test_directed();
        test_random_round();
        test_random_round();
        src_idle_pct = 84;
        snk_idle_pct = 32;
        test_table_full();
        test_random_round();
        test_random_round();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_long_stall();
        test_random_round();
        test_random_round();

        wait_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
